FILE: hw/rtl/atu_pkg.sv
// atu_pkg: shared types, widths and the cordic arctangent table
`default_nettype none
package atu_pkg;

  localparam int SUM_W  = 17;  // sample plus offset, signed
  localparam int SQR_W  = 34;  // sum of two squares, unsigned
  localparam int SQ_NW  = 52;  // radicand width: sum of squares times 2^16, even
  localparam int SQ_RW  = SQ_NW / 2;  // root width, 8 fraction bits
  localparam int XW     = 30;  // cordic x and y width, signed
  localparam int ZW     = 26;  // cordic angle width, degrees * 2^16, signed
  localparam int TAB_LEN = 24;

  localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  localparam logic [22:0] ATAN_TAB [0:TAB_LEN-1] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

  typedef enum logic [1:0] {
    REG_OFFSET_X   = 2'd0,
    REG_OFFSET_Y   = 2'd1,
    REG_OFFSET_Z   = 2'd2,
    REG_ANGLE_BIAS = 2'd3
  } atu_reg_t;

  // per-lane flags that ride along with the cordic
  typedef struct packed {
    logic num_zero;
    logic den_zero;
    logic num_neg;
  } atu_side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/atu_if.sv
// atu_if: valid/ready channels for samples and angles
`default_nettype none
interface atu_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atu_angle_if;
  logic        valid;
  logic        ready;
  logic [15:0] pitch_deg;
  logic [15:0] roll_deg;
  logic [15:0] yaw_deg;
  modport source (output valid, pitch_deg, roll_deg, yaw_deg, input ready);
  modport sink   (input valid, pitch_deg, roll_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/accel_tilt_angles_unit.sv
// accel_tilt_angles_unit: pipelined tilt angles of a three-axis accelerometer sample
//
// channel   dir  payload                              transfer when
// sample    in   accel_x, accel_y, accel_z (s16)      sample.valid && sample.ready
// angles    out  pitch_deg, roll_deg, yaw_deg (u16)   angles.valid && angles.ready
// config    in   wr_index (2b), wr_data (16b)         wr_en
//
// one sample per cycle sustained while the output is not stalled; the pipeline runs
// front end, 26-stage square root, cordic entry and rotations, output register
// the square root pipeline depth, one root bit per stage, sets most of the latency
// synchronous active-high reset clears valid bits and loads the register defaults
// one stall signal freezes every stage at once, so nothing is dropped or repeated
`default_nettype none
module accel_tilt_angles_unit
  import atu_pkg::*;
#(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  atu_sample_if.sink       sample,
  atu_angle_if.source      angles,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [15:0] wr_data
);

  // more stages than the table holds run as the full table
  localparam int RUN_STAGES = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int SH         = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [31:0] HALF = 32'sd1 <<< (SH - 1);
  localparam logic signed [31:0] FULL = 32'sd360 <<< ANGLE_FRAC_BITS;

  // configuration registers
  logic signed [15:0] off_x, off_y, off_z;
  logic [15:0]        bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
      bias  <= 16'd10944;
    end else if (wr_en) begin
      unique case (atu_reg_t'(wr_index))
        REG_OFFSET_X:   off_x <= wr_data;
        REG_OFFSET_Y:   off_y <= wr_data;
        REG_OFFSET_Z:   off_z <= wr_data;
        REG_ANGLE_BIAS: bias  <= wr_data;
        default: ;
      endcase
    end
  end

  // global advance: the whole pipe moves unless a result sits unaccepted
  logic adv;
  assign adv          = ~angles.valid | angles.ready;
  assign sample.ready = adv;

  // front end: offsets, squares, sums of squares
  logic                    fr_valid;
  logic [2:0][SUM_W-1:0]   fr_num;
  logic [2:0][SQR_W-1:0]   fr_sq;

  atu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .valid_i (sample.valid),
    .ax      (sample.accel_x),
    .ay      (sample.accel_y),
    .az      (sample.accel_z),
    .off_x   (off_x),
    .off_y   (off_y),
    .off_z   (off_z),
    .valid_o (fr_valid),
    .num_o   (fr_num),
    .sq_o    (fr_sq)
  );

  // per angle lane: square root, cordic, then round, bias and wrap
  logic [2:0]        lane_valid;
  logic [2:0][15:0]  lane_deg;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic                 sq_valid;
    logic [SUM_W-1:0]     sq_num;
    logic [SQ_RW-1:0]     sq_root;
    logic                 co_valid;
    atu_side_t            co_side;
    logic signed [ZW-1:0] co_z;
    logic signed [ZW-1:0] z_sel;
    logic signed [31:0]   z_rnd, total;

    atu_sqrt u_sqrt (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .valid_i (fr_valid),
      .num_i   (fr_num[l]),
      .sq_i    (fr_sq[l]),
      .valid_o (sq_valid),
      .num_o   (sq_num),
      .root_o  (sq_root)
    );

    atu_cordic #(
      .STAGES (RUN_STAGES)
    ) u_cordic (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .valid_i (sq_valid),
      .num_i   (sq_num),
      .den_i   (sq_root),
      .valid_o (co_valid),
      .side_o  (co_side),
      .z_o     (co_z)
    );

    // zero numerator gives zero; zero root gives a signed right angle
    always_comb begin
      if (co_side.num_zero) begin
        z_sel = '0;
      end else if (co_side.den_zero) begin
        z_sel = co_side.num_neg ? -DEG90 : DEG90;
      end else begin
        z_sel = co_z;
      end
      z_rnd = (32'(z_sel) + HALF) >>> SH;
      total = z_rnd + $signed({16'b0, bias});
      if (total < 0) begin
        total = total + FULL;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lane_valid[l] <= 1'b0;
      end else if (adv) begin
        lane_valid[l] <= co_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lane_deg[l] <= total[15:0];
      end
    end
  end

  assign angles.valid     = &lane_valid;
  assign angles.pitch_deg = lane_deg[0];
  assign angles.roll_deg  = lane_deg[1];
  assign angles.yaw_deg   = lane_deg[2];

  // the three lanes always carry the same items
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    lane_valid[0] == lane_valid[1] && lane_valid[1] == lane_valid[2])
    else $error("angle lanes out of step");

  // an accepted sample enters the front end on the next edge
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> u_front.v_a)
    else $error("sample transfer lost");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !angles.valid)
    else $error("result valid after reset");

  // a stalled output freezes the pipe and holds the result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (angles.valid && !angles.ready) |=> $stable(lane_deg) && angles.valid)
    else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: hw/rtl/atu_front.sv
// atu_front: offset add, squares and per-angle sums of squares
`default_nettype none
module atu_front
  import atu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  valid_i,
  input  wire logic signed [15:0]    ax,
  input  wire logic signed [15:0]    ay,
  input  wire logic signed [15:0]    az,
  input  wire logic signed [15:0]    off_x,
  input  wire logic signed [15:0]    off_y,
  input  wire logic signed [15:0]    off_z,
  output logic                       valid_o,
  output logic [2:0][SUM_W-1:0]      num_o,
  output logic [2:0][SQR_W-1:0]      sq_o
);

  logic                    v_a, v_b;
  logic signed [SUM_W-1:0] sx, sy, sz, bx, by, bz;
  logic [SQR_W-2:0]        qx, qy, qz;
  logic signed [2*SUM_W-1:0] px, py, pz;

  assign px = sx * sx;
  assign py = sy * sy;
  assign pz = sz * sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a     <= 1'b0;
      v_b     <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v_a     <= valid_i;
      v_b     <= v_a;
      valid_o <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= SUM_W'(ax) + SUM_W'(off_x);
      sy <= SUM_W'(ay) + SUM_W'(off_y);
      sz <= SUM_W'(az) + SUM_W'(off_z);
      qx <= px[SQR_W-2:0];
      qy <= py[SQR_W-2:0];
      qz <= pz[SQR_W-2:0];
      bx <= sx;
      by <= sy;
      bz <= sz;
      // lane 0 pitch, lane 1 roll, lane 2 yaw
      num_o[0] <= by;
      num_o[1] <= bx;
      num_o[2] <= bz;
      sq_o[0]  <= {1'b0, qx} + {1'b0, qz};
      sq_o[1]  <= {1'b0, qy} + {1'b0, qz};
      sq_o[2]  <= {1'b0, qx} + {1'b0, qy};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/atu_sqrt.sv
// atu_sqrt: pipelined restoring square root, one root bit per stage
`default_nettype none
module atu_sqrt
  import atu_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    valid_i,
  input  wire logic [SUM_W-1:0]        num_i,
  input  wire logic [SQR_W-1:0]        sq_i,
  output logic                         valid_o,
  output logic [SUM_W-1:0]             num_o,
  output logic [SQ_RW-1:0]             root_o
);

  logic                vld_q  [1:SQ_RW];
  logic [SUM_W-1:0]    num_q  [1:SQ_RW];
  logic [SQ_RW+1:0]    rem_q  [1:SQ_RW];
  logic [SQ_RW-1:0]    root_q [1:SQ_RW];
  logic [SQ_NW-1:0]    rad_q  [1:SQ_RW];

  for (genvar k = 0; k < SQ_RW; k++) begin : g_stage
    logic               v_in;
    logic [SUM_W-1:0]   n_in;
    logic [SQ_RW+1:0]   r_in;
    logic [SQ_RW-1:0]   q_in;
    logic [SQ_NW-1:0]   d_in;
    logic [SQ_RW+3:0]   cat, trial, diff;
    logic               take;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = num_i;
      assign r_in = '0;
      assign q_in = '0;
      assign d_in = {2'b00, sq_i, 16'b0};
    end else begin : g_next
      assign v_in = vld_q[k];
      assign n_in = num_q[k];
      assign r_in = rem_q[k];
      assign q_in = root_q[k];
      assign d_in = rad_q[k];
    end

    assign cat   = {r_in, d_in[SQ_NW-1:SQ_NW-2]};
    assign trial = {2'b00, q_in, 2'b01};
    assign diff  = cat - trial;
    assign take  = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[k+1]  <= n_in;
        rem_q[k+1]  <= take ? diff[SQ_RW+1:0] : cat[SQ_RW+1:0];
        root_q[k+1] <= {q_in[SQ_RW-2:0], take};
        rad_q[k+1]  <= {d_in[SQ_NW-3:0], 2'b00};
      end
    end
  end

  assign valid_o = vld_q[SQ_RW];
  assign num_o   = num_q[SQ_RW];
  assign root_o  = root_q[SQ_RW];

endmodule
`default_nettype wire

FILE: hw/rtl/atu_cordic.sv
// atu_cordic: pipelined vectoring cordic giving atan(num / den) in degrees
`default_nettype none
module atu_cordic
  import atu_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    valid_i,
  input  wire logic [SUM_W-1:0]        num_i,
  input  wire logic [SQ_RW-1:0]        den_i,
  output logic                         valid_o,
  output atu_side_t                    side_o,
  output logic signed [ZW-1:0]         z_o
);

  logic                vld_q  [0:STAGES];
  atu_side_t           side_q [0:STAGES];
  logic signed [XW-1:0] x_q   [0:STAGES];
  logic signed [XW-1:0] y_q   [0:STAGES];
  logic signed [ZW-1:0] z_q   [0:STAGES];

  // entry register: x = root, y = numerator * 2^8
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0].num_zero <= (num_i == '0);
      side_q[0].den_zero <= (den_i == '0);
      side_q[0].num_neg  <= num_i[SUM_W-1];
      x_q[0] <= {{(XW-SQ_RW){1'b0}}, den_i};
      y_q[0] <= {{(XW-SUM_W-8){num_i[SUM_W-1]}}, num_i, 8'b0};
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [ZW-1:0] t;
    logic                 up;

    assign t  = {{(ZW-23){1'b0}}, ATAN_TAB[i]};
    assign up = ~y_q[i][XW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i+1] <= side_q[i];
        if (up) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + t;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - t;
        end
      end
    end
  end

  assign valid_o = vld_q[STAGES];
  assign side_o  = side_q[STAGES];
  assign z_o     = z_q[STAGES];

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// testbench: checks accel_tilt_angles_unit against a cycle-free angle predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench
  import atu_pkg::*;
();

  localparam int STAGES     = 16;
  localparam int FRAC       = 7;
  localparam int LATENCY    = 3 + 26 + 1 + STAGES + 1;
  localparam int STALL_LIM  = 5000;
  localparam int RAND_ITEMS = 1600;
  localparam longint FULL_TURN = 360 << FRAC;

  typedef struct {
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] yaw;
  } angles_t;

  // one sample, optionally with its angles typed in
  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    bit                 typed;
    angles_t            want;
  } sample_t;

  logic clk;
  logic rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [15:0] wr_data;

  atu_sample_if sample_ch ();
  atu_angle_if  angle_ch ();

  accel_tilt_angles_unit #(
    .CORDIC_STAGES  (STAGES),
    .ANGLE_FRAC_BITS(FRAC)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .angles  (angle_ch),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  // mirror of the calibration registers
  logic signed [15:0] cal_x, cal_y, cal_z;
  logic [15:0]        cal_bias;

  sample_t pending_samples[$];
  angles_t expected_angles[$];
  int      err_cnt = 0;
  bit      send_hold = 0;
  int      recv_hold = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // angle predictor
  // ---------------------------------------------------------------------------

  // atan(a / sqrt(b^2 + c^2)) in degrees * 2^16, via root and vectoring cordic
  function automatic longint tilt_angle(longint a, longint b, longint c);
    longint unsigned rad, root, one;
    longint          cx, cy, cz, cx_old;
    rad  = longint'(b * b + c * c) << 16;
    root = 0;
    one  = 64'd1 << 60;
    while (one > rad) one = one >> 2;
    while (one != 0) begin
      if (rad >= root + one) begin
        rad  = rad - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    if (a == 0) return 0;
    // no denominator: straight up or straight down
    if (root == 0) return (a > 0) ? (longint'(90) << 16) : -(longint'(90) << 16);
    cx = longint'(root);
    cy = a * 256;
    cz = 0;
    for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
      cx_old = cx;
      if (cy >= 0) begin
        cx = cx + (cy >>> i);
        cy = cy - (cx_old >>> i);
        cz = cz + longint'(ATAN_TAB[i]);
      end else begin
        cx = cx - (cy >>> i);
        cy = cy + (cx_old >>> i);
        cz = cz - longint'(ATAN_TAB[i]);
      end
    end
    return cz;
  endfunction

  // round to the output format, add the bias, wrap a negative total once
  function automatic logic [15:0] to_output(longint z16);
    longint r;
    r = (z16 + (longint'(1) << (16 - FRAC - 1))) >>> (16 - FRAC);
    r = r + longint'(cal_bias);
    if (r < 0) r = r + FULL_TURN;
    return r[15:0];
  endfunction

  function automatic angles_t predict_angles(sample_t s);
    angles_t a;
    longint  sx, sy, sz;
    sx = longint'(s.ax) + longint'(cal_x);
    sy = longint'(s.ay) + longint'(cal_y);
    sz = longint'(s.az) + longint'(cal_z);
    a.pitch = to_output(tilt_angle(sy, sx, sz));
    a.roll  = to_output(tilt_angle(sx, sy, sz));
    a.yaw   = to_output(tilt_angle(sz, sx, sy));
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // sample sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  sample_t on_wire;
  int      burst_left = 0;
  int      gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid   <= 1'b0;
      sample_ch.accel_x <= '0;
      sample_ch.accel_y <= '0;
      sample_ch.accel_z <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // transfer at this edge: log what its angles should be
      if (sample_ch.valid && sample_ch.ready)
        expected_angles.push_back(on_wire.typed ? on_wire.want : predict_angles(on_wire));
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left > 0 || send_hold || pending_samples.size() == 0) begin
          sample_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          on_wire = pending_samples.pop_front();
          sample_ch.valid   <= 1'b1;
          sample_ch.accel_x <= on_wire.ax;
          sample_ch.accel_y <= on_wire.ay;
          sample_ch.accel_z <= on_wire.az;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            // sometimes no gap at all, sometimes a long one
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 3);
              2: gap_left = $urandom_range(1, 12);
              default: gap_left = $urandom_range(0, 60);
            endcase
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // angle receiver: stalls on a rotating pattern, plus a requested long hold-off
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pat;
  int          pat_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      angle_ch.ready <= 1'b0;
      stall_pat = 16'hffff;
    end else if (recv_hold > 0) begin
      recv_hold--;
      angle_ch.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hffff;  // no stalls at all
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
        if (stall_pat == '0) stall_pat = 16'h0001;
      end
      pat_left--;
      angle_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // result check, oldest expectation first
  // ---------------------------------------------------------------------------
  angles_t want_now;

  always @(posedge clk) begin
    if (!rst && angle_ch.valid && angle_ch.ready) begin
      if (expected_angles.size() == 0) begin
        $error("unexpected angle transfer pitch=%0d roll=%0d yaw=%0d",
               angle_ch.pitch_deg, angle_ch.roll_deg, angle_ch.yaw_deg);
        err_cnt++;
      end else begin
        want_now = expected_angles.pop_front();
        if (angle_ch.pitch_deg !== want_now.pitch) begin
          $error("pitch_deg: expected %0d, actual %0d", want_now.pitch, angle_ch.pitch_deg);
          err_cnt++;
        end
        if (angle_ch.roll_deg !== want_now.roll) begin
          $error("roll_deg: expected %0d, actual %0d", want_now.roll, angle_ch.roll_deg);
          err_cnt++;
        end
        if (angle_ch.yaw_deg !== want_now.yaw) begin
          $error("yaw_deg: expected %0d, actual %0d", want_now.yaw, angle_ch.yaw_deg);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (angle_ch.valid && angle_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIM) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // pipeline is empty: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_ch.valid || expected_angles.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(atu_reg_t idx, logic [15:0] value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    case (idx)
      REG_OFFSET_X:   cal_x = value;
      REG_OFFSET_Y:   cal_y = value;
      REG_OFFSET_Z:   cal_z = value;
      REG_ANGLE_BIAS: cal_bias = value;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_calibration(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                                 logic [15:0] bias);
    wait_drained();
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_ANGLE_BIAS, bias);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom);                 // anywhere
      5, 6:          return 16'($signed($urandom_range(0, 4000)) - 2000);  // small, within 2000 of zero
      7:             return 16'h0000;                       // axis at rest
      8:             return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default:       return 16'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  task automatic queue_random(int count);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      s.ax = rand_axis();
      s.ay = rand_axis();
      s.az = rand_axis();
      s.typed = 1'b0;
      pending_samples.push_back(s);
    end
  endtask

  // directed samples; typed angles assume reset calibration
  sample_t directed[] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{16'd10944, 16'd10944, 16'd10944}},
    '{16'sd1000,   16'sd0,      16'sd0,      1'b1, '{16'd10944, 16'd22464, 16'd10944}},
    '{-16'sd1000,  16'sd0,      16'sd0,      1'b1, '{16'd10944, 16'd45504, 16'd10944}},
    '{16'sd0,      16'sd1,      16'sd0,      1'b1, '{16'd22464, 16'd10944, 16'd10944}},
    '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, '{16'd10944, 16'd10944, 16'd45504}},
    '{16'sd0,      16'sd0,      16'sd32767,  1'b1, '{16'd10944, 16'd10944, 16'd22464}},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '{16'd0, 16'd0, 16'd0}},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'sd32767,  -16'sd32768, 16'sd0,      1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'sd0,      16'sd0,      16'sd1000,   1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'sd1,      16'sd1,      16'sd1,      1'b0, '{16'd0, 16'd0, 16'd0}},
    '{-16'sd1,     16'sd1,      -16'sd1,     1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'sd707,    16'sd0,      16'sd707,    1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'sd1,      16'sd32767,  16'sd0,      1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'sd5461,   -16'sd21845, 16'sd10922,  1'b0, '{16'd0, 16'd0, 16'd0}}
  };

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    wr_en    = 1'b0;
    wr_index = REG_OFFSET_X;
    wr_data  = '0;
    cal_x    = '0;
    cal_y    = '0;
    cal_z    = '0;
    cal_bias = 16'd10944;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table at reset calibration
    foreach (directed[i]) pending_samples.push_back(directed[i]);

    // long receiver hold-off while samples keep coming, so the input backs up
    queue_random(200);
    while (pending_samples.size() > 150) @(posedge clk);
    recv_hold = 300;
    while (pending_samples.size() != 0) @(posedge clk);

    // sender waits until every outstanding angle is back, then resumes
    send_hold = 1'b1;
    while (expected_angles.size() != 0 || sample_ch.valid) @(posedge clk);
    send_hold = 1'b0;
    queue_random(150);

    // offsets at their extremes, zero bias: totals wrap negative
    set_calibration(16'h8000, 16'h7fff, 16'h8000, 16'd0);
    queue_random(250);

    set_calibration(16'h7fff, 16'h8000, 16'h7fff, 16'd46080);
    queue_random(250);

    // full 16-bit bias: only the low bits of the total survive
    set_calibration(16'h0000, 16'h0000, 16'h0000, 16'hffff);
    queue_random(250);

    // random calibration, small offsets as a real sensor would need
    set_calibration(16'($signed($urandom_range(0, 200)) - 100),
                    16'($signed($urandom_range(0, 200)) - 100),
                    16'($signed($urandom_range(0, 200)) - 100),
                    16'($urandom_range(0, 46080)));
    queue_random(250);

    set_calibration(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    queue_random(RAND_ITEMS - 1350);

    wait_drained();
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/atu_pkg.sv
hw/rtl/atu_if.sv
hw/rtl/atu_front.sv
hw/rtl/atu_sqrt.sv
hw/rtl/atu_cordic.sv
hw/rtl/accel_tilt_angles_unit.sv
bench/testbench.sv
